// ----- hdl/weighted_class_vote_window_assert.svh -----
// assertion macros used by the checker file
`ifndef WEIGHTED_CLASS_VOTE_WINDOW_ASSERT_SVH
`define WEIGHTED_CLASS_VOTE_WINDOW_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define WCV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled while reset is low
`define WCV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- hdl/wcv_pkg.sv -----
package wcv_pkg;

    // default parameter values
    localparam int DEF_WINDOW_SIDE = 7;
    localparam int DEF_CLASS_COUNT = 16;
    localparam int DEF_LABEL_BITS  = 4;

    // fixed field geometry
    localparam int CLASS_SLOTS    = 16;
    localparam int CLASS_IDX_BITS = 4;
    localparam int WEIGHT_BITS    = 6;
    localparam int WEIGHT_MAX     = 63;
    localparam int SCORE_BITS     = 12;
    localparam int LABEL_WIDE_BITS = 64;
    localparam int LABEL_LAST_BITS = 4;
    localparam int LABEL_VEC_BITS = 3 * LABEL_WIDE_BITS + LABEL_LAST_BITS;
    localparam int SCORE_WIDE_BITS = 5 * SCORE_BITS;

    // configuration port
    localparam int REG_COUNT      = 5;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 60;
    localparam int CFG_LAST_BITS  = 54;
    localparam int WEIGHT_VEC_BITS = 4 * CFG_DATA_BITS + CFG_LAST_BITS;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_W_0_9   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_W_10_19 = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_W_20_29 = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_W_30_39 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_W_40_48 = 3'd4;

    // all sixteen scores, class c at bits 12c+11..12c
    typedef logic [CLASS_SLOTS-1:0][SCORE_BITS-1:0] t_score_vec;

endpackage

// ----- hdl/wcv_if.sv -----
// window channel: one 7x7 label window per transaction
interface wcv_in_if;
    import wcv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [LABEL_WIDE_BITS-1:0] labels_0_15;
    logic [LABEL_WIDE_BITS-1:0] labels_16_31;
    logic [LABEL_WIDE_BITS-1:0] labels_32_47;
    logic [LABEL_LAST_BITS-1:0] label_48;

    modport source (output valid, labels_0_15, labels_16_31, labels_32_47, label_48,
                    input ready);
    modport sink   (input valid, labels_0_15, labels_16_31, labels_32_47, label_48,
                    output ready);
endinterface

// score channel: sixteen class scores per transaction
interface wcv_out_if;
    import wcv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [SCORE_WIDE_BITS-1:0] scores_0_4;
    logic [SCORE_WIDE_BITS-1:0] scores_5_9;
    logic [SCORE_WIDE_BITS-1:0] scores_10_14;
    logic [SCORE_BITS-1:0]      score_15;

    modport source (output valid, scores_0_4, scores_5_9, scores_10_14, score_15,
                    input ready);
    modport sink   (input valid, scores_0_4, scores_5_9, scores_10_14, score_15,
                    output ready);
endinterface

// ----- hdl/wcv_row_lane.sv -----
// one window row: per-class sums of the weights of its positions
module wcv_row_lane #(
    parameter int WINDOW_SIDE = wcv_pkg::DEF_WINDOW_SIDE,
    parameter int CLASS_COUNT = wcv_pkg::DEF_CLASS_COUNT,
    parameter int LABEL_BITS  = wcv_pkg::DEF_LABEL_BITS,
    parameter int ROW_BITS    = $clog2(WINDOW_SIDE * wcv_pkg::WEIGHT_MAX + 1)
) (
    input  logic                                       i_clk,
    input  logic                                       i_load,
    input  logic [WINDOW_SIDE*LABEL_BITS-1:0]          i_labels,
    input  logic [WINDOW_SIDE*wcv_pkg::WEIGHT_BITS-1:0] i_weights,
    output logic [wcv_pkg::CLASS_SLOTS-1:0][ROW_BITS-1:0] o_sums
);
    import wcv_pkg::*;

    logic [CLASS_SLOTS-1:0][ROW_BITS-1:0] n_sums;
    logic [CLASS_SLOTS-1:0][ROW_BITS-1:0] r_sums;
    logic [WINDOW_SIDE-1:0][CLASS_IDX_BITS-1:0] lab_ext;

    // widen each label to a class index
    always_comb begin
        for (int k = 0; k < WINDOW_SIDE; k++) begin
            lab_ext[k] = CLASS_IDX_BITS'(i_labels[k*LABEL_BITS +: LABEL_BITS]);
        end
    end

    // per class, add the weights of matching positions in this row
    always_comb begin
        for (int c = 0; c < CLASS_SLOTS; c++) begin
            n_sums[c] = '0;
            for (int k = 0; k < WINDOW_SIDE; k++) begin
                if (c < CLASS_COUNT && lab_ext[k] == CLASS_IDX_BITS'(c)) begin
                    n_sums[c] = n_sums[c]
                              + ROW_BITS'(i_weights[k*WEIGHT_BITS +: WEIGHT_BITS]);
                end
            end
        end
    end

    // stage one register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sums <= n_sums;
        end
    end

    assign o_sums = r_sums;

endmodule

// ----- hdl/wcv_merge.sv -----
// merging stage: adds the row partials of every class
module wcv_merge #(
    parameter int WINDOW_SIDE = wcv_pkg::DEF_WINDOW_SIDE,
    parameter int ROW_BITS    = $clog2(WINDOW_SIDE * wcv_pkg::WEIGHT_MAX + 1)
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_load,
    input  logic [WINDOW_SIDE-1:0][wcv_pkg::CLASS_SLOTS-1:0][ROW_BITS-1:0] i_rows,
    output wcv_pkg::t_score_vec                                    o_scores
);
    import wcv_pkg::*;

    t_score_vec n_scores;
    t_score_vec r_scores;

    // column sum over the rows
    always_comb begin
        for (int c = 0; c < CLASS_SLOTS; c++) begin
            n_scores[c] = '0;
            for (int r = 0; r < WINDOW_SIDE; r++) begin
                n_scores[c] = n_scores[c] + SCORE_BITS'(i_rows[r][c]);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_scores <= n_scores;
        end
    end

    assign o_scores = r_scores;

endmodule

// ----- hdl/weighted_class_vote_window.sv -----
// channel   | dir | transaction carries
// ----------+-----+-----------------------------------------------
// i_win     | in  | one label window, 49 positions of 4 bits
// o_score   | out | sixteen 12-bit class scores
// i_cfg_*   | in  | weight register write, no handshake
//
// one transaction per cycle sustained while o_score.ready does not stall; registered in the row lanes, then the merge
// each pipeline stage has its own valid bit, so a new window is taken while a
// finished result waits on o_score.ready, as long as the row-lane stage is empty
// reset clears the valid bits and the weight registers to zero
// weight writes apply to windows accepted after the write edge
module weighted_class_vote_window #(
    parameter int WINDOW_SIDE = wcv_pkg::DEF_WINDOW_SIDE,
    parameter int CLASS_COUNT = wcv_pkg::DEF_CLASS_COUNT,
    parameter int LABEL_BITS  = wcv_pkg::DEF_LABEL_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    wcv_in_if.sink                              i_win,
    wcv_out_if.source                           o_score,
    input  logic                                i_cfg_we,
    input  logic [wcv_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [wcv_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import wcv_pkg::*;

    localparam int ROW_BITS = $clog2(WINDOW_SIDE * WEIGHT_MAX + 1);

    logic [REG_COUNT-1:0][CFG_DATA_BITS-1:0] r_weights;
    logic [WEIGHT_VEC_BITS-1:0] weight_vec;
    logic [LABEL_VEC_BITS-1:0]  label_vec;
    logic [WINDOW_SIDE-1:0][CLASS_SLOTS-1:0][ROW_BITS-1:0] row_sums;
    t_score_vec scores;

    logic r_v1;
    logic r_v2;
    logic ready1;
    logic ready2;
    logic load1;
    logic load2;

    // weight register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_W_0_9:   r_weights[0] <= i_cfg_data;
                CFG_W_10_19: r_weights[1] <= i_cfg_data;
                CFG_W_20_29: r_weights[2] <= i_cfg_data;
                CFG_W_30_39: r_weights[3] <= i_cfg_data;
                CFG_W_40_48: r_weights[4] <= CFG_DATA_BITS'(i_cfg_data[CFG_LAST_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // flat vectors, position p weight at 6p and label at p*LABEL_BITS
    assign weight_vec = {r_weights[4][CFG_LAST_BITS-1:0], r_weights[3], r_weights[2],
                         r_weights[1], r_weights[0]};
    assign label_vec  = {i_win.label_48, i_win.labels_32_47, i_win.labels_16_31,
                         i_win.labels_0_15};

    // stage handshake
    assign ready2 = !r_v2 || o_score.ready;
    assign ready1 = !r_v1 || ready2;
    assign load1  = i_win.valid && ready1;
    assign load2  = r_v1 && ready2;
    assign i_win.ready = ready1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_win.valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // one lane per window row
    for (genvar r = 0; r < WINDOW_SIDE; r++) begin : g_lane
        wcv_row_lane #(
            .WINDOW_SIDE (WINDOW_SIDE),
            .CLASS_COUNT (CLASS_COUNT),
            .LABEL_BITS  (LABEL_BITS),
            .ROW_BITS    (ROW_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_load    (load1),
            .i_labels  (label_vec[r*WINDOW_SIDE*LABEL_BITS +: WINDOW_SIDE*LABEL_BITS]),
            .i_weights (weight_vec[r*WINDOW_SIDE*WEIGHT_BITS +: WINDOW_SIDE*WEIGHT_BITS]),
            .o_sums    (row_sums[r])
        );
    end

    // combine the rows into class scores
    wcv_merge #(
        .WINDOW_SIDE (WINDOW_SIDE),
        .ROW_BITS    (ROW_BITS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_load   (load2),
        .i_rows   (row_sums),
        .o_scores (scores)
    );

    // result packing
    assign o_score.valid        = r_v2;
    assign o_score.scores_0_4   = scores[4:0];
    assign o_score.scores_5_9   = scores[9:5];
    assign o_score.scores_10_14 = scores[14:10];
    assign o_score.score_15     = scores[15];

endmodule

// ----- hdl/wcv_checker.sv -----
`include "weighted_class_vote_window_assert.svh"

// port-level checks of the vote pipeline
module wcv_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [wcv_pkg::SCORE_WIDE_BITS-1:0] i_scores_0_4,
    input logic [wcv_pkg::SCORE_BITS-1:0]      i_score_15
);
    // a stalled result stays offered
    `WCV_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // a stalled result keeps its scores 0 to 4 and score 15
    `WCV_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_scores_0_4) && $stable(i_score_15))

    // with the output stage empty the input side is always open
    `WCV_ASSERT_IMP(a_in_open, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // a window reaches the output through the row lane and merge registers when nothing stalls it
    `WCV_ASSERT_NXT(a_latency, i_clk, i_rst_n, (i_in_valid && i_in_ready) ##1 (!i_out_valid || i_out_ready), i_out_valid)

endmodule

bind weighted_class_vote_window wcv_checker u_wcv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_win.valid),
    .i_in_ready   (i_win.ready),
    .i_out_valid  (o_score.valid),
    .i_out_ready  (o_score.ready),
    .i_scores_0_4 (o_score.scores_0_4),
    .i_score_15   (o_score.score_15)
);
